// ----- hw/rtl/threshold_alarm_with_acknowledge_assert.svh -----
// assertion helpers shared by the alarm block
`ifndef THRESHOLD_ALARM_WITH_ACKNOWLEDGE_ASSERT_SVH
`define THRESHOLD_ALARM_WITH_ACKNOWLEDGE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TAA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/taa_pkg.sv -----
package taa_pkg;

   localparam int unsigned READING_WIDTH_DEF = 16;
   localparam int unsigned NUM_CHAN          = 3;
   localparam int unsigned CHAN_IDX_W        = 2;

   // channel indexes
   localparam logic [CHAN_IDX_W-1:0] CH_TEMP = 2'd0;
   localparam logic [CHAN_IDX_W-1:0] CH_HUM  = 2'd1;
   localparam logic [CHAN_IDX_W-1:0] CH_TC   = 2'd2;

   // priority order, highest first
   localparam logic [CHAN_IDX_W-1:0] PRIO_ORDER [NUM_CHAN] = '{CH_TC, CH_TEMP, CH_HUM};

   // request opcodes
   localparam logic OP_EVALUATE = 1'b0;
   localparam logic OP_ACK      = 1'b1;

   // register map
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_HUM_LOW     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_HUM_HIGH    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TC_LOW      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_TC_HIGH     = 3'd6;

   typedef struct packed {
      logic step;
      logic ack;
      logic live;
   } chan_cmd_type;

   typedef struct packed {
      logic active;
      logic above;
   } chan_flags_type;

endpackage

// ----- hw/rtl/taa_req_if.sv -----
interface taa_req_if #(
   parameter int unsigned READING_WIDTH = taa_pkg::READING_WIDTH_DEF
);
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic signed [READING_WIDTH-1:0] temp_reading;
   logic signed [READING_WIDTH-1:0] hum_reading;
   logic signed [READING_WIDTH-1:0] tc_reading;
   logic                            temp_hum_ok;
   logic                            tc_ok;

   modport source (
      output valid, opcode, temp_reading, hum_reading, tc_reading, temp_hum_ok, tc_ok,
      input  ready
   );

   modport sink (
      input  valid, opcode, temp_reading, hum_reading, tc_reading, temp_hum_ok, tc_ok,
      output ready
   );
endinterface

// ----- hw/rtl/taa_rsp_if.sv -----
interface taa_rsp_if #(
   parameter int unsigned READING_WIDTH = taa_pkg::READING_WIDTH_DEF
);
   import taa_pkg::*;

   logic                            valid;
   logic                            ready;
   logic                            alarm_active;
   logic [CHAN_IDX_W-1:0]           top_channel;
   logic signed [READING_WIDTH-1:0] top_reading;
   logic signed [READING_WIDTH-1:0] top_limit;
   logic                            top_above;
   logic [CHAN_IDX_W-1:0]           extra_active;

   modport source (
      output valid, alarm_active, top_channel, top_reading, top_limit, top_above,
             extra_active,
      input  ready
   );

   modport sink (
      input  valid, alarm_active, top_channel, top_reading, top_limit, top_above,
             extra_active,
      output ready
   );
endinterface

// ----- hw/rtl/threshold_alarm_with_acknowledge.sv -----
// channel     | dir | handshake                 | payload
// req_chan    | in  | valid / ready             | opcode, three readings, two ok flags
// rsp_chan    | out | valid / ready             | alarm summary, top channel details
// csr_*       | in  | apb psel/penable, pready  | enable mask, six limits
//
// one request per cycle while results are taken; input register, then result register
// the input register feeds the channel state update and the result register in one pass
// a stalled result register holds the input register, which then drops req ready
// synchronous active-high reset idles every channel and restores the default limits
`include "threshold_alarm_with_acknowledge_assert.svh"

module threshold_alarm_with_acknowledge #(
   parameter int unsigned READING_WIDTH = taa_pkg::READING_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   taa_req_if.sink                           req_chan,
   taa_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [taa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [taa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [taa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import taa_pkg::*;

   // configuration
   logic [NUM_CHAN-1:0]             enable_mask;
   logic signed [READING_WIDTH-1:0] low_limit  [NUM_CHAN];
   logic signed [READING_WIDTH-1:0] high_limit [NUM_CHAN];

   // input register
   logic                            in_valid_ff, in_valid_in;
   logic                            in_opcode_ff;
   logic signed [READING_WIDTH-1:0] in_reading_ff [NUM_CHAN];
   logic                            in_th_ok_ff;
   logic                            in_tc_ok_ff;

   // result register
   logic                            out_valid_ff, out_valid_in;
   logic                            out_alarm_ff;
   logic [CHAN_IDX_W-1:0]           out_channel_ff;
   logic signed [READING_WIDTH-1:0] out_reading_ff;
   logic signed [READING_WIDTH-1:0] out_limit_ff;
   logic                            out_above_ff;
   logic [CHAN_IDX_W-1:0]           out_extra_ff;

   // channel update and selection
   logic                            advance;
   logic                            req_take;
   logic [NUM_CHAN-1:0]             chan_ok;
   chan_cmd_type                    chan_cmd [NUM_CHAN];
   chan_flags_type                  nxt_flags [NUM_CHAN];
   logic signed [READING_WIDTH-1:0] nxt_reading [NUM_CHAN];
   logic signed [READING_WIDTH-1:0] nxt_limit [NUM_CHAN];
   logic                            sel_alarm;
   logic [CHAN_IDX_W-1:0]           sel_channel;
   logic signed [READING_WIDTH-1:0] sel_reading;
   logic signed [READING_WIDTH-1:0] sel_limit;
   logic                            sel_above;
   logic [CHAN_IDX_W-1:0]           sel_extra;

   // register file
   assign csr_pready = 1'b1;

   taa_csr #(
      .READING_WIDTH (READING_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .enable_mask (enable_mask),
      .low_limit   (low_limit),
      .high_limit  (high_limit)
   );

   // the held request moves on when the result register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff           <= req_chan.opcode;
         in_reading_ff[CH_TEMP] <= req_chan.temp_reading;
         in_reading_ff[CH_HUM]  <= req_chan.hum_reading;
         in_reading_ff[CH_TC]   <= req_chan.tc_reading;
         in_th_ok_ff            <= req_chan.temp_hum_ok;
         in_tc_ok_ff            <= req_chan.tc_ok;
      end
   end

   // temperature and humidity share one ok flag
   always_comb begin
      chan_ok[CH_TEMP] = in_th_ok_ff;
      chan_ok[CH_HUM]  = in_th_ok_ff;
      chan_ok[CH_TC]   = in_tc_ok_ff;
   end

   for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
      always_comb begin
         chan_cmd[i].step = advance;
         chan_cmd[i].ack  = (in_opcode_ff == OP_ACK);
         chan_cmd[i].live = chan_ok[i] && enable_mask[i];
      end

      taa_chan #(
         .READING_WIDTH (READING_WIDTH)
      ) u_chan (
         .clock       (clock),
         .reset       (reset),
         .cmd         (chan_cmd[i]),
         .reading     (in_reading_ff[i]),
         .low_limit   (low_limit[i]),
         .high_limit  (high_limit[i]),
         .nxt_flags   (nxt_flags[i]),
         .nxt_reading (nxt_reading[i]),
         .nxt_limit   (nxt_limit[i])
      );
   end

   // summary is built from the post-update channel state
   taa_select #(
      .READING_WIDTH (READING_WIDTH)
   ) u_select (
      .flags        (nxt_flags),
      .reading      (nxt_reading),
      .limit        (nxt_limit),
      .alarm_active (sel_alarm),
      .top_channel  (sel_channel),
      .top_reading  (sel_reading),
      .top_limit    (sel_limit),
      .top_above    (sel_above),
      .extra_active (sel_extra)
   );

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_alarm_ff   <= sel_alarm;
         out_channel_ff <= sel_channel;
         out_reading_ff <= sel_reading;
         out_limit_ff   <= sel_limit;
         out_above_ff   <= sel_above;
         out_extra_ff   <= sel_extra;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.alarm_active = out_alarm_ff;
   assign rsp_chan.top_channel  = out_channel_ff;
   assign rsp_chan.top_reading  = out_reading_ff;
   assign rsp_chan.top_limit    = out_limit_ff;
   assign rsp_chan.top_above    = out_above_ff;
   assign rsp_chan.extra_active = out_extra_ff;

   `TAA_ASSERT_SAME(a_quiet_result_zero, clock, reset, out_valid_ff && !out_alarm_ff,
      (out_channel_ff == '0) && (out_reading_ff == '0) && (out_limit_ff == '0)
      && !out_above_ff && (out_extra_ff == '0))
   `TAA_ASSERT_SAME(a_full_pipe_stalls, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_chan.ready, !req_chan.ready)
   `TAA_ASSERT_NEXT(a_take_fills_input, clock, reset, req_take, in_valid_ff)
   `TAA_ASSERT_SAME(a_extra_in_range, clock, reset, out_valid_ff && out_alarm_ff,
      (out_extra_ff != 2'd3) && (out_channel_ff != 2'd3))

endmodule

// ----- hw/rtl/taa_csr.sv -----
module taa_csr #(
   parameter int unsigned READING_WIDTH = taa_pkg::READING_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [taa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [taa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [taa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic [taa_pkg::NUM_CHAN-1:0]      enable_mask,
   output logic signed [READING_WIDTH-1:0]   low_limit  [taa_pkg::NUM_CHAN],
   output logic signed [READING_WIDTH-1:0]   high_limit [taa_pkg::NUM_CHAN]
);
   import taa_pkg::*;

   localparam logic signed [READING_WIDTH-1:0] LIMIT_MIN =
      {1'b1, {(READING_WIDTH-1){1'b0}}};
   localparam logic signed [READING_WIDTH-1:0] LIMIT_MAX =
      {1'b0, {(READING_WIDTH-1){1'b1}}};

   logic [NUM_CHAN-1:0]              enable_ff, enable_in;
   logic signed [READING_WIDTH-1:0]  low_ff  [NUM_CHAN];
   logic signed [READING_WIDTH-1:0]  low_in  [NUM_CHAN];
   logic signed [READING_WIDTH-1:0]  high_ff [NUM_CHAN];
   logic signed [READING_WIDTH-1:0]  high_in [NUM_CHAN];
   logic [REG_IDX_W-1:0]             reg_idx;
   logic                             wr_en;
   logic signed [READING_WIDTH-1:0]  wr_value;

   assign reg_idx  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en    = csr_psel && csr_penable && csr_pwrite;
   assign wr_value = csr_pwdata[READING_WIDTH-1:0];

   always_comb begin
      enable_in = enable_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ENABLE_MASK: enable_in = csr_pwdata[NUM_CHAN-1:0];
            REG_TEMP_LOW:    low_in[CH_TEMP]  = wr_value;
            REG_TEMP_HIGH:   high_in[CH_TEMP] = wr_value;
            REG_HUM_LOW:     low_in[CH_HUM]   = wr_value;
            REG_HUM_HIGH:    high_in[CH_HUM]  = wr_value;
            REG_TC_LOW:      low_in[CH_TC]    = wr_value;
            REG_TC_HIGH:     high_in[CH_TC]   = wr_value;
            default:         enable_in = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            low_ff[i]  <= LIMIT_MIN;
            high_ff[i] <= LIMIT_MAX;
         end
      end else begin
         enable_ff <= enable_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
      end
   end

   // limits read back sign extended
   always_comb begin
      unique case (reg_idx)
         REG_ENABLE_MASK: csr_prdata = CSR_DATA_W'(enable_ff);
         REG_TEMP_LOW:    csr_prdata = CSR_DATA_W'(low_ff[CH_TEMP]);
         REG_TEMP_HIGH:   csr_prdata = CSR_DATA_W'(high_ff[CH_TEMP]);
         REG_HUM_LOW:     csr_prdata = CSR_DATA_W'(low_ff[CH_HUM]);
         REG_HUM_HIGH:    csr_prdata = CSR_DATA_W'(high_ff[CH_HUM]);
         REG_TC_LOW:      csr_prdata = CSR_DATA_W'(low_ff[CH_TC]);
         REG_TC_HIGH:     csr_prdata = CSR_DATA_W'(high_ff[CH_TC]);
         default:         csr_prdata = '0;
      endcase
   end

   assign enable_mask = enable_ff;
   assign low_limit   = low_ff;
   assign high_limit  = high_ff;

endmodule

// ----- hw/rtl/taa_chan.sv -----
`include "threshold_alarm_with_acknowledge_assert.svh"

module taa_chan #(
   parameter int unsigned READING_WIDTH = taa_pkg::READING_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  taa_pkg::chan_cmd_type            cmd,
   input  logic signed [READING_WIDTH-1:0]  reading,
   input  logic signed [READING_WIDTH-1:0]  low_limit,
   input  logic signed [READING_WIDTH-1:0]  high_limit,
   output taa_pkg::chan_flags_type          nxt_flags,
   output logic signed [READING_WIDTH-1:0]  nxt_reading,
   output logic signed [READING_WIDTH-1:0]  nxt_limit
);
   import taa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ACTIVE = 2'd1,
      ST_ACKED  = 2'd2
   } state_type;

   state_type                       state_ff, state_in;
   logic signed [READING_WIDTH-1:0] reading_ff, reading_in;
   logic signed [READING_WIDTH-1:0] limit_ff, limit_in;
   logic                            above_ff, above_in;
   logic                            hi, lo;

   assign hi = reading > high_limit;
   assign lo = reading < low_limit;

   always_comb begin
      state_in   = state_ff;
      reading_in = reading_ff;
      limit_in   = limit_ff;
      above_in   = above_ff;
      if (cmd.step) begin
         if (cmd.ack) begin
            if (state_ff == ST_ACTIVE) begin
               state_in = ST_ACKED;
            end
         end else if (!cmd.live) begin
            state_in = ST_IDLE;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  // high violation wins over low
                  if (hi) begin
                     state_in   = ST_ACTIVE;
                     reading_in = reading;
                     limit_in   = high_limit;
                     above_in   = 1'b1;
                  end else if (lo) begin
                     state_in   = ST_ACTIVE;
                     reading_in = reading;
                     limit_in   = low_limit;
                     above_in   = 1'b0;
                  end
               end
               ST_ACTIVE: reading_in = reading;
               ST_ACKED: begin
                  if (!hi && !lo) begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         reading_ff <= '0;
         limit_ff   <= '0;
         above_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         reading_ff <= reading_in;
         limit_ff   <= limit_in;
         above_ff   <= above_in;
      end
   end

   assign nxt_flags.active = (state_in == ST_ACTIVE);
   assign nxt_flags.above  = above_in;
   assign nxt_reading      = reading_in;
   assign nxt_limit        = limit_in;

   `TAA_ASSERT_NEXT(a_ack_moves_active, clock, reset,
      cmd.step && cmd.ack && (state_ff == ST_ACTIVE), state_ff == ST_ACKED)
   `TAA_ASSERT_NEXT(a_dead_forces_idle, clock, reset,
      cmd.step && !cmd.ack && !cmd.live, state_ff == ST_IDLE)
   `TAA_ASSERT_NEXT(a_hold_without_step, clock, reset, !cmd.step, $stable(state_ff))

endmodule

// ----- hw/rtl/taa_select.sv -----
module taa_select #(
   parameter int unsigned READING_WIDTH = taa_pkg::READING_WIDTH_DEF
) (
   input  taa_pkg::chan_flags_type                flags   [taa_pkg::NUM_CHAN],
   input  logic signed [READING_WIDTH-1:0]        reading [taa_pkg::NUM_CHAN],
   input  logic signed [READING_WIDTH-1:0]        limit   [taa_pkg::NUM_CHAN],
   output logic                                   alarm_active,
   output logic [taa_pkg::CHAN_IDX_W-1:0]         top_channel,
   output logic signed [READING_WIDTH-1:0]        top_reading,
   output logic signed [READING_WIDTH-1:0]        top_limit,
   output logic                                   top_above,
   output logic [taa_pkg::CHAN_IDX_W-1:0]         extra_active
);
   import taa_pkg::*;

   logic [NUM_CHAN-1:0]   active_vec;
   logic [CHAN_IDX_W-1:0] num_active;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         active_vec[i] = flags[i].active;
      end
   end

   assign num_active = CHAN_IDX_W'($countones(active_vec));

   // walk from lowest priority up so the highest active channel wins
   always_comb begin
      alarm_active = 1'b0;
      top_channel  = '0;
      top_reading  = '0;
      top_limit    = '0;
      top_above    = 1'b0;
      extra_active = '0;
      for (int p = NUM_CHAN - 1; p >= 0; p--) begin
         if (active_vec[PRIO_ORDER[p]]) begin
            alarm_active = 1'b1;
            top_channel  = PRIO_ORDER[p];
            top_reading  = reading[PRIO_ORDER[p]];
            top_limit    = limit[PRIO_ORDER[p]];
            top_above    = flags[PRIO_ORDER[p]].above;
         end
      end
      if (alarm_active) begin
         extra_active = num_active - CHAN_IDX_W'(1);
      end
   end

endmodule

// ----- dv/tb_threshold_alarm_with_acknowledge.sv -----
`timescale 1ns / 100ps

module tb_threshold_alarm_with_acknowledge;
   import taa_pkg::*;

   localparam int unsigned RW               = READING_WIDTH_DEF;
   localparam int unsigned CLOCK_PERIOD     = 20;
   localparam int unsigned RESET_CYCLES     = 7;
   // time to pass the input and result registers, plus margin
   localparam int unsigned SETTLE_CYCLES    = 6;
   localparam int unsigned HOLDOFF_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned DRAIN_LIMIT      = 5000;
   localparam int unsigned RANDOM_PER_PHASE = 400;
   localparam int unsigned HOLDOFF_REQUESTS = 80;
   localparam int unsigned MAX_PRINTED      = 40;
   localparam int unsigned ACK_PCT          = 15;
   localparam int unsigned READING_OK_PCT   = 92;

   // index 7 decodes to no register
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam logic [REG_IDX_W-1:0] LOW_REG  [NUM_CHAN] = '{REG_TEMP_LOW, REG_HUM_LOW, REG_TC_LOW};
   localparam logic [REG_IDX_W-1:0] HIGH_REG [NUM_CHAN] =
      '{REG_TEMP_HIGH, REG_HUM_HIGH, REG_TC_HIGH};

   localparam logic signed [RW-1:0] READING_MIN = {1'b1, {(RW-1){1'b0}}};
   localparam logic signed [RW-1:0] READING_MAX = {1'b0, {(RW-1){1'b1}}};

   // idle percentages per random phase: sender, then receiver
   localparam int unsigned SEND_GAP [3] = '{19, 50, 0};
   localparam int unsigned RSP_GAP  [3] = '{50, 19, 0};

   typedef enum logic [1:0] {
      CHAN_IDLE   = 2'd0,
      CHAN_ACTIVE = 2'd1,
      CHAN_ACKED  = 2'd2
   } chan_state_type;

   typedef enum int {
      LIMITS_TYPICAL,
      LIMITS_RAILS,
      LIMITS_SCATTERED
   } limit_style_type;

   typedef struct packed {
      logic                 opcode;
      logic signed [RW-1:0] temp_reading;
      logic signed [RW-1:0] hum_reading;
      logic signed [RW-1:0] tc_reading;
      logic                 temp_hum_ok;
      logic                 tc_ok;
   } alarm_request_type;

   typedef struct packed {
      logic                  alarm_active;
      logic [CHAN_IDX_W-1:0] top_channel;
      logic signed [RW-1:0]  top_reading;
      logic signed [RW-1:0]  top_limit;
      logic                  top_above;
      logic [CHAN_IDX_W-1:0] extra_active;
   } alarm_summary_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   taa_req_if #(.READING_WIDTH(RW)) req_if ();
   taa_rsp_if #(.READING_WIDTH(RW)) rsp_if ();

   threshold_alarm_with_acknowledge #(.READING_WIDTH(RW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the register file and the three channel alarms
   logic [NUM_CHAN-1:0]  enable_mask_q;
   logic signed [RW-1:0] low_limit_q    [NUM_CHAN];
   logic signed [RW-1:0] high_limit_q   [NUM_CHAN];
   chan_state_type       chan_state_q   [NUM_CHAN];
   logic signed [RW-1:0] chan_reading_q [NUM_CHAN];
   logic signed [RW-1:0] chan_limit_q   [NUM_CHAN];
   logic                 chan_above_q   [NUM_CHAN];

   // summaries still owed by the block, oldest first
   alarm_summary_type pending_summaries [$];

   int unsigned send_gap_pct;
   int unsigned rsp_gap_pct;
   logic        rsp_holding;
   event        holdoff_kick;

   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned sent_count;
   int unsigned ack_count;
   int unsigned checked_count;
   int unsigned alarm_count;
   int unsigned csr_writes;
   int unsigned csr_reads;
   int unsigned stall_cycles;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_summaries.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // long receiver stall, counted here so the sender keeps pushing
   initial begin : holdoff_counter
      int unsigned n;
      rsp_holding = 1'b0;
      forever begin
         @(holdoff_kick);
         rsp_holding <= 1'b1;
         for (n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clock);
         rsp_holding <= 1'b0;
      end
   end

   // random result back-pressure
   initial begin : rsp_ready_driver
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !rsp_holding && ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string what, input logic signed [63:0] got_v,
                              input logic signed [63:0] want_v);
      if (got_v !== want_v)
         report_mismatch($sformatf("%s got %0d, expected %0d", what, got_v, want_v));
   endtask

   function automatic void reset_shadow();
      int i;
      enable_mask_q = '0;
      for (i = 0; i < NUM_CHAN; i++) begin
         low_limit_q[i]    = READING_MIN;
         high_limit_q[i]   = READING_MAX;
         chan_state_q[i]   = CHAN_IDLE;
         chan_reading_q[i] = '0;
         chan_limit_q[i]   = '0;
         chan_above_q[i]   = 1'b0;
      end
   endfunction

   // advance the channel alarms by one request and build the summary it yields
   function automatic alarm_summary_type annunciate(input alarm_request_type r);
      alarm_summary_type     s;
      logic signed [RW-1:0]  reading [NUM_CHAN];
      logic                  usable  [NUM_CHAN];
      logic                  hi;
      logic                  lo;
      int unsigned           active_n;
      int                    i;
      logic [CHAN_IDX_W-1:0] c;
      s        = '0;
      active_n = 0;
      reading[CH_TEMP] = r.temp_reading;
      reading[CH_HUM]  = r.hum_reading;
      reading[CH_TC]   = r.tc_reading;
      usable[CH_TEMP]  = r.temp_hum_ok & enable_mask_q[CH_TEMP];
      usable[CH_HUM]   = r.temp_hum_ok & enable_mask_q[CH_HUM];
      usable[CH_TC]    = r.tc_ok & enable_mask_q[CH_TC];

      if (r.opcode == OP_EVALUATE) begin
         for (i = 0; i < NUM_CHAN; i++) begin
            if (!usable[i]) begin
               chan_state_q[i] = CHAN_IDLE;
            end else begin
               hi = reading[i] > high_limit_q[i];
               lo = reading[i] < low_limit_q[i];
               case (chan_state_q[i])
                  CHAN_IDLE: begin
                     // high side wins when both limits are crossed
                     if (hi || lo) begin
                        chan_state_q[i]   = CHAN_ACTIVE;
                        chan_reading_q[i] = reading[i];
                        chan_above_q[i]   = hi;
                        chan_limit_q[i]   = hi ? high_limit_q[i] : low_limit_q[i];
                     end
                  end
                  CHAN_ACTIVE: chan_reading_q[i] = reading[i];
                  default: begin
                     // acknowledged: re-arm only once back in range
                     if (!hi && !lo) chan_state_q[i] = CHAN_IDLE;
                  end
               endcase
            end
         end
      end else begin
         for (i = 0; i < NUM_CHAN; i++)
            if (chan_state_q[i] == CHAN_ACTIVE) chan_state_q[i] = CHAN_ACKED;
      end

      for (i = 0; i < NUM_CHAN; i++) begin
         c = PRIO_ORDER[i];
         if (chan_state_q[c] == CHAN_ACTIVE) begin
            if (active_n == 0) begin
               s.alarm_active = 1'b1;
               s.top_channel  = c;
               s.top_reading  = chan_reading_q[c];
               s.top_limit    = chan_limit_q[c];
               s.top_above    = chan_above_q[c];
            end
            active_n++;
         end
      end
      if (active_n != 0) s.extra_active = CHAN_IDX_W'(active_n - 1);
      return s;
   endfunction

   // result checker: every accepted summary against the oldest one owed
   always @(posedge clock) begin : summary_checker
      alarm_summary_type got;
      alarm_summary_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.alarm_active = rsp_if.alarm_active;
         got.top_channel  = rsp_if.top_channel;
         got.top_reading  = rsp_if.top_reading;
         got.top_limit    = rsp_if.top_limit;
         got.top_above    = rsp_if.top_above;
         got.extra_active = rsp_if.extra_active;
         if (pending_summaries.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_summaries.pop_front();
            checked_count++;
            if (want.alarm_active) alarm_count++;
            check_field("alarm_active", got.alarm_active, want.alarm_active);
            check_field("top_channel", got.top_channel, want.top_channel);
            check_field("top_reading", got.top_reading, want.top_reading);
            check_field("top_limit", got.top_limit, want.top_limit);
            check_field("top_above", got.top_above, want.top_above);
            check_field("extra_active", got.extra_active, want.extra_active);
         end
      end
   end

   // one request: optional idle gap, then hold valid until accepted
   // valid stays high afterwards so back-to-back requests need no re-raise
   task automatic send_request(input alarm_request_type r);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= r.opcode;
      req_if.temp_reading <= r.temp_reading;
      req_if.hum_reading  <= r.hum_reading;
      req_if.tc_reading   <= r.tc_reading;
      req_if.temp_hum_ok  <= r.temp_hum_ok;
      req_if.tc_ok        <= r.tc_ok;
      @(posedge clock);
      while (!req_if.ready) begin
         stall_cycles++;
         @(posedge clock);
      end
      pending_summaries.push_back(annunciate(r));
      sent_count++;
      if (r.opcode == OP_ACK) ack_count++;
   endtask

   task automatic send_eval(input int t, input int h, input int tc, input logic th_ok,
                            input logic tc_good);
      alarm_request_type r;
      r.opcode       = OP_EVALUATE;
      r.temp_reading = RW'(t);
      r.hum_reading  = RW'(h);
      r.tc_reading   = RW'(tc);
      r.temp_hum_ok  = th_ok;
      r.tc_ok        = tc_good;
      send_request(r);
   endtask

   // acknowledge carries junk readings and flags, all of which must be ignored
   task automatic send_ack();
      alarm_request_type r;
      r.opcode       = OP_ACK;
      r.temp_reading = RW'($urandom());
      r.hum_reading  = RW'($urandom());
      r.tc_reading   = RW'($urandom());
      r.temp_hum_ok  = 1'($urandom());
      r.tc_ok        = 1'($urandom());
      send_request(r);
   endtask

   // readings clustered around the current limits, plus rails and noise
   function automatic logic signed [RW-1:0] pick_reading(input int ch);
      int unsigned sel;
      int          base;
      sel = $urandom_range(9);
      if (sel == 0) return RW'($urandom());
      if (sel == 1) return $urandom_range(1) ? READING_MAX : READING_MIN;
      base = (sel < 6) ? int'(high_limit_q[ch]) : int'(low_limit_q[ch]);
      return RW'(base + int'($urandom_range(8)) - 4);
   endfunction

   task automatic send_random_request();
      alarm_request_type r;
      r.opcode       = ($urandom_range(99) < ACK_PCT) ? OP_ACK : OP_EVALUATE;
      r.temp_reading = pick_reading(CH_TEMP);
      r.hum_reading  = pick_reading(CH_HUM);
      r.tc_reading   = pick_reading(CH_TC);
      r.temp_hum_ok  = ($urandom_range(99) < READING_OK_PCT);
      r.tc_ok        = ($urandom_range(99) < READING_OK_PCT);
      send_request(r);
   endtask

   // stop offering requests and let the pipeline empty before touching registers
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write, setup then access; psel is left high for back-to-back transfers
   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      int ch;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_writes++;
      // unmapped index falls through every match and is dropped
      if (idx == REG_ENABLE_MASK) enable_mask_q = data[NUM_CHAN-1:0];
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         if (idx == LOW_REG[ch]) low_limit_q[ch] = data[RW-1:0];
         if (idx == HIGH_REG[ch]) high_limit_q[ch] = data[RW-1:0];
      end
   endtask

   task automatic read_csr(input logic [REG_IDX_W-1:0] idx, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_reads++;
   endtask

   // bus back to idle so a held access phase never repeats a write
   task automatic idle_csr();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // read every register back, compare the live bits, then release the bus
   task automatic check_registers();
      logic [CSR_DATA_W-1:0] word;
      int                    ch;
      read_csr(REG_ENABLE_MASK, word);
      check_field("enable mask read-back", word[NUM_CHAN-1:0], enable_mask_q);
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         read_csr(LOW_REG[ch], word);
         check_field($sformatf("channel %0d low limit read-back", ch),
                     $signed(word[RW-1:0]), low_limit_q[ch]);
         read_csr(HIGH_REG[ch], word);
         check_field($sformatf("channel %0d high limit read-back", ch),
                     $signed(word[RW-1:0]), high_limit_q[ch]);
      end
      idle_csr();
   endtask

   // upper data bits are random and must not matter
   task automatic set_enable(input logic [NUM_CHAN-1:0] mask);
      logic [CSR_DATA_W-1:0] w;
      w               = $urandom();
      w[NUM_CHAN-1:0] = mask;
      write_csr(REG_ENABLE_MASK, w);
   endtask

   task automatic set_limits(input int ch, input logic signed [RW-1:0] low,
                             input logic signed [RW-1:0] high);
      logic [CSR_DATA_W-1:0] w;
      w         = $urandom();
      w[RW-1:0] = low;
      write_csr(LOW_REG[ch], w);
      w         = $urandom();
      w[RW-1:0] = high;
      write_csr(HIGH_REG[ch], w);
   endtask

   task automatic apply_random_settings(input limit_style_type style);
      int ch;
      int lo;
      quiesce();
      set_enable(($urandom_range(99) < 75) ? 3'b111 : NUM_CHAN'($urandom_range(7)));
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         case (style)
            LIMITS_TYPICAL: begin
               lo = int'($urandom_range(2000)) - 1000;
               set_limits(ch, RW'(lo), RW'(lo + int'($urandom_range(1500, 1))));
            end
            LIMITS_RAILS: begin
               // rails in order never trip, swapped they trip on almost anything
               if ($urandom_range(1)) set_limits(ch, READING_MIN, READING_MAX);
               else set_limits(ch, READING_MAX, READING_MIN);
            end
            default: set_limits(ch, RW'($urandom()), RW'($urandom()));
         endcase
      end
      if ($urandom_range(3) == 0) write_csr(REG_UNMAPPED, $urandom());
      check_registers();
   endtask

   // reset values on the register port, nothing can alarm at rail limits
   task automatic test_register_defaults();
      check_registers();
      send_eval(READING_MAX, READING_MIN, READING_MAX, 1'b1, 1'b1);
      send_eval(READING_MIN, READING_MAX, READING_MIN, 1'b1, 1'b1);
      quiesce();
      set_enable(3'b111);
      check_registers();
      send_eval(READING_MAX, READING_MIN, READING_MAX, 1'b1, 1'b1);
      send_eval(READING_MIN, READING_MAX, READING_MIN, 1'b1, 1'b1);
   endtask

   // walk every channel through trip, acknowledge and re-arm, and refresh active readings
   task automatic test_alarm_lifecycle();
      quiesce();
      set_limits(CH_TEMP, RW'(-100), RW'(300));
      set_limits(CH_HUM, RW'(200), RW'(800));
      set_limits(CH_TC, RW'(-500), RW'(1500));
      check_registers();
      send_eval(0, 500, 0, 1'b1, 1'b1);        // all in range
      send_eval(301, 500, 0, 1'b1, 1'b1);      // temp one step above high
      send_eval(350, 500, 0, 1'b1, 1'b1);      // active temp refreshes its reading
      send_eval(320, 199, 0, 1'b1, 1'b1);      // hum trips low, temp stays on top
      send_eval(330, 150, 1501, 1'b1, 1'b1);   // tc outranks both others
      send_ack();                              // siren off
      send_eval(400, 500, 1600, 1'b1, 1'b1);   // acked temp not refreshed, hum re-arms
      send_eval(300, 100, 1500, 1'b1, 1'b1);   // readings on the limit count as in range
      send_eval(READING_MAX, 90, READING_MAX, 1'b1, 1'b0); // bad tc forced idle
      send_eval(-101, 90, 0, 1'b0, 1'b1);      // bad temp/hum forces both idle
      send_eval(READING_MIN, READING_MAX, READING_MIN, 1'b1, 1'b1); // everything trips
      send_ack();
      send_eval(-100, 800, -500, 1'b1, 1'b1);  // back on the limits, all re-arm
      quiesce();
      set_enable(3'b000);
      idle_csr();
      send_eval(READING_MIN, READING_MAX, READING_MIN, 1'b1, 1'b1); // all disabled
      quiesce();
      set_enable(3'b010);
      idle_csr();
      send_eval(READING_MAX, READING_MIN, READING_MAX, 1'b1, 1'b1); // hum alone trips
      quiesce();
      set_enable(3'b101);
      idle_csr();
      send_eval(0, READING_MIN, 0, 1'b1, 1'b1);  // disabling hum drops its alarm
   endtask

   // low limit above high limit, swapped rails and the unmapped register
   task automatic test_inverted_limits();
      quiesce();
      set_enable(3'b111);
      set_limits(CH_TEMP, READING_MAX, READING_MIN);
      set_limits(CH_HUM, RW'(500), RW'(100));
      set_limits(CH_TC, READING_MIN, READING_MAX);
      write_csr(REG_UNMAPPED, '1);
      check_registers();
      send_eval(0, 300, READING_MAX, 1'b1, 1'b1);          // both crossed, high side wins
      send_eval(0, 300, 0, 1'b0, 1'b1);                    // back to idle
      send_eval(READING_MIN, 50, READING_MIN, 1'b1, 1'b1); // only the low side crossed
      send_eval(READING_MIN, 100, READING_MIN, 1'b1, 1'b1);
      send_ack();
      send_eval(READING_MAX, 300, 0, 1'b1, 1'b1);          // still out, stays acked
   endtask

   // three idle mixes with the register settings reshuffled along the way
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned n;
      int unsigned until_reconfig;
      int unsigned style;
      style = 0;
      for (phase = 0; phase < 3; phase++) begin
         send_gap_pct   = SEND_GAP[phase];
         rsp_gap_pct    = RSP_GAP[phase];
         until_reconfig = 0;
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (until_reconfig == 0) begin
               apply_random_settings(limit_style_type'(style % 3));
               style++;
               until_reconfig = $urandom_range(120, 60);
            end
            until_reconfig--;
            send_random_request();
         end
      end
   endtask

   // receiver holds off while requests keep coming until the input backs up
   task automatic test_output_holdoff();
      int unsigned n;
      apply_random_settings(LIMITS_TYPICAL);
      send_gap_pct = 0;
      rsp_gap_pct  = 0;
      -> holdoff_kick;
      for (n = 0; n < HOLDOFF_REQUESTS; n++) send_random_request();
   endtask

   initial begin
      int unsigned waited;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.opcode       = OP_EVALUATE;
      req_if.temp_reading = '0;
      req_if.hum_reading  = '0;
      req_if.tc_reading   = '0;
      req_if.temp_hum_ok  = 1'b0;
      req_if.tc_ok        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      send_gap_pct        = 0;
      rsp_gap_pct         = 0;
      error_count         = 0;
      sent_count          = 0;
      ack_count           = 0;
      checked_count       = 0;
      alarm_count         = 0;
      csr_writes          = 0;
      csr_reads           = 0;
      stall_cycles        = 0;
      reset_shadow();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_alarm_lifecycle();
      test_inverted_limits();
      test_random_traffic();
      test_output_holdoff();

      // drain whatever is still in flight
      req_if.valid <= 1'b0;
      waited = 0;
      while (pending_summaries.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_summaries.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_summaries.size()));

      $display("covered %0d requests (%0d acknowledges), %0d results checked, %0d alarming",
               sent_count, ack_count, checked_count, alarm_count);
      $display("%0d register writes, %0d read-backs, %0d cycles of input held off, %0d errors",
               csr_writes, csr_reads, stall_cycles, error_count);
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- threshold_alarm_with_acknowledge.f -----
+incdir+hw/rtl
hw/rtl/taa_pkg.sv
hw/rtl/taa_req_if.sv
hw/rtl/taa_rsp_if.sv
hw/rtl/taa_csr.sv
hw/rtl/taa_chan.sv
hw/rtl/taa_select.sv
hw/rtl/threshold_alarm_with_acknowledge.sv
dv/tb_threshold_alarm_with_acknowledge.sv
